// ===== rtl/knn_pkg.sv =====
package knn_pkg;

    localparam int COORD_W    = 16;
    localparam int VAL_W      = 16;
    localparam int NUM_VAL    = 3;
    localparam int SQ_W       = 32;
    localparam int DIST_W     = 33;
    localparam int FOUND_W    = 4;
    localparam int NC_W       = 4;
    localparam int DL_W       = 16;
    localparam int PC_W       = 9;
    localparam int PIDX_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT    = 2'd2;

    typedef logic signed [VAL_W-1:0] val_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctl_t;

endpackage

// ===== rtl/knn_radius_average.sv =====
// Nearest-neighbor averaging over a point memory. A word with s_tuser = 0 loads a
// point (coordinates and three values) into slot point_index. A word with
// s_tuser = 1 is a query: it streams slots 0 .. min(point_count, MAX_POINTS)-1 out
// of the memory at one read per cycle, squares the distance to the query, drops
// points at or beyond distance_limit and pushes the rest through a chain of
// MAX_NEIGHBORS insertion cells that keeps the nearest ones sorted (ties to the
// lower slot). The first k cells are then summed, one per cycle, and each column
// is divided by k in a bit-serial divider of SUM_W = 17 + log2(MAX_NEIGHBORS)
// bits (20 by default). Loads are taken only while no query is in flight. The
// result register lets a new word in while a result waits on m_tready. Slots
// never loaded return undefined data to a query.
module knn_radius_average #(
    parameter int MAX_POINTS    = 256,
    parameter int MAX_NEIGHBORS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // point_index, coord_x, coord_y, value_first, value_second, value_third
    input  logic [87:0]                     s_tdata,
    // func
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // mean_first, mean_second, mean_third, found_count, zero fill
    output logic [55:0]                     m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [knn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [knn_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import knn_pkg::*;

    localparam int AW        = $clog2(MAX_POINTS);
    localparam int CW        = $clog2(MAX_POINTS + 1);
    localparam int KW        = $clog2(MAX_NEIGHBORS + 1);
    localparam int JW        = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int SUM_W     = VAL_W + $clog2(MAX_NEIGHBORS) + 1;
    localparam int KEY_W     = DIST_W + AW;
    localparam int DATA_W    = NUM_VAL * VAL_W;
    localparam int MEM_W     = 2 * COORD_W + DATA_W;
    localparam int DRAIN_LEN = MAX_NEIGHBORS + 3;
    localparam int DRW       = $clog2(DRAIN_LEN);
    localparam int DVW       = $clog2(SUM_W);
    localparam int OUT_W     = 56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_SUM,
        ST_DIVLD,
        ST_DIV,
        ST_DONE
    } state_t;

    // configuration
    logic [NC_W-1:0] nc_reg, nc_next;
    logic [DL_W-1:0] dl_reg, dl_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic [KW-1:0]   k_eff;
    logic [CW-1:0]   n_eff;

    // control
    state_t                 state_reg, state_next;
    logic [CW-1:0]          addr_reg, addr_next;
    logic [DRW-1:0]         drn_reg, drn_next;
    logic [JW-1:0]          j_reg, j_next;
    logic [DVW-1:0]         dcnt_reg, dcnt_next;
    logic [KW-1:0]          found_reg, found_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]       m_tdata_reg, m_tdata_next;
    logic signed [COORD_W-1:0] qx_reg, qx_next;
    logic signed [COORD_W-1:0] qy_reg, qy_next;
    logic [SQ_W-1:0]        lim2_reg, lim2_next;
    logic signed [SUM_W-1:0] sum_reg [NUM_VAL];
    logic signed [SUM_W-1:0] sum_next [NUM_VAL];
    logic                   rd_vld_next;
    logic                   clr_chain;
    div_ctl_t               div_ctl;
    logic [OUT_W-1:0]       out_word;

    logic s_acc;
    logic func;

    // point memory and scan pipeline
    logic [MEM_W-1:0]  mem [MAX_POINTS];
    logic [MEM_W-1:0]  rd_data_reg;
    logic              rd_vld_reg;
    logic [AW-1:0]     rd_idx_reg;
    logic              ld_we;
    logic [AW-1:0]     ld_addr;

    logic signed [COORD_W-1:0]   px, py;
    logic signed [COORD_W:0]     dx, dy;
    logic signed [2*COORD_W+1:0] prod_x, prod_y;
    logic [SQ_W-1:0]   sqx_reg, sqy_reg;
    logic [DATA_W-1:0] s1_data_reg;
    logic [AW-1:0]     s1_idx_reg;
    logic              s1_vld_reg;
    logic [DIST_W-1:0] d2;
    logic              cand_vld_reg;
    logic [KEY_W-1:0]  cand_key_reg;
    logic [DATA_W-1:0] cand_data_reg;

    // insertion chain
    logic              ch_vld  [MAX_NEIGHBORS+1];
    logic [KEY_W-1:0]  ch_key  [MAX_NEIGHBORS+1];
    logic [DATA_W-1:0] ch_data [MAX_NEIGHBORS+1];
    logic              hold_vld  [MAX_NEIGHBORS];
    logic [DATA_W-1:0] hold_data [MAX_NEIGHBORS];
    logic              sel_vld;
    logic [DATA_W-1:0] sel_data;

    val_t quot [NUM_VAL];

    assign func     = s_tuser[0];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    assign k_eff = (nc_reg == '0) ? KW'(1) :
                   ((32'(nc_reg) > MAX_NEIGHBORS) ? KW'(MAX_NEIGHBORS) : KW'(nc_reg));
    assign n_eff = (32'(pc_reg) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(pc_reg);

    // ---------------- point memory ----------------
    assign ld_addr = AW'(s_tdata[PIDX_W-1:0]);
    assign ld_we   = s_acc && !func && (32'(s_tdata[PIDX_W-1:0]) < MAX_POINTS);

    always_ff @(posedge aclk) begin
        if (ld_we) begin
            mem[ld_addr] <= s_tdata[PIDX_W +: MEM_W];
        end
        rd_data_reg <= mem[addr_reg[AW-1:0]];
    end

    // ---------------- distance pipeline ----------------
    assign px     = rd_data_reg[0 +: COORD_W];
    assign py     = rd_data_reg[COORD_W +: COORD_W];
    assign dx     = (COORD_W+1)'(qx_reg) - (COORD_W+1)'(px);
    assign dy     = (COORD_W+1)'(qy_reg) - (COORD_W+1)'(py);
    assign prod_x = dx * dx;
    assign prod_y = dy * dy;
    assign d2     = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            s1_vld_reg   <= 1'b0;
            cand_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= rd_vld_next;
            s1_vld_reg   <= rd_vld_reg;
            cand_vld_reg <= s1_vld_reg && (d2 < DIST_W'(lim2_reg));
        end
        rd_idx_reg    <= addr_reg[AW-1:0];
        sqx_reg       <= prod_x[SQ_W-1:0];
        sqy_reg       <= prod_y[SQ_W-1:0];
        s1_data_reg   <= rd_data_reg[2*COORD_W +: DATA_W];
        s1_idx_reg    <= rd_idx_reg;
        cand_key_reg  <= {d2, s1_idx_reg};
        cand_data_reg <= s1_data_reg;
    end

    // ---------------- insertion chain ----------------
    assign ch_vld[0]  = cand_vld_reg;
    assign ch_key[0]  = cand_key_reg;
    assign ch_data[0] = cand_data_reg;

    for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_cell
        knn_cell #(
            .KEY_W  (KEY_W),
            .DATA_W (DATA_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clr       (clr_chain),
            .in_vld    (ch_vld[g]),
            .in_key    (ch_key[g]),
            .in_data   (ch_data[g]),
            .fwd_vld   (ch_vld[g+1]),
            .fwd_key   (ch_key[g+1]),
            .fwd_data  (ch_data[g+1]),
            .hold_vld  (hold_vld[g]),
            .hold_data (hold_data[g])
        );
    end

    assign sel_vld  = hold_vld[j_reg];
    assign sel_data = hold_data[j_reg];

    // ---------------- dividers ----------------
    for (genvar c = 0; c < NUM_VAL; c++) begin : g_div
        knn_div #(
            .SUM_W (SUM_W),
            .K_W   (KW)
        ) u_div (
            .aclk     (aclk),
            .ctl      (div_ctl),
            .dividend (sum_reg[c]),
            .divisor  (k_eff),
            .quotient (quot[c])
        );
    end

    always_comb begin
        out_word = '0;
        for (int c = 0; c < NUM_VAL; c++) begin
            out_word[c*VAL_W +: VAL_W] = quot[c];
        end
        out_word[DATA_W +: FOUND_W] = FOUND_W'(found_reg);
    end

    // ---------------- control ----------------
    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        drn_next      = drn_reg;
        j_next        = j_reg;
        dcnt_next     = dcnt_reg;
        found_next    = found_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        qx_next       = qx_reg;
        qy_next       = qy_reg;
        lim2_next     = lim2_reg;
        nc_next       = nc_reg;
        dl_next       = dl_reg;
        pc_next       = pc_reg;
        rd_vld_next   = 1'b0;
        clr_chain     = 1'b0;
        div_ctl       = '0;
        for (int c = 0; c < NUM_VAL; c++) begin
            sum_next[c] = sum_reg[c];
        end

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NEIGHBOR_COUNT: nc_next = cfg_wdata[NC_W-1:0];
                CFG_DISTANCE_LIMIT: dl_next = cfg_wdata[DL_W-1:0];
                CFG_POINT_COUNT:    pc_next = cfg_wdata[PC_W-1:0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && func) begin
                    clr_chain  = 1'b1;
                    qx_next    = s_tdata[PIDX_W +: COORD_W];
                    qy_next    = s_tdata[PIDX_W+COORD_W +: COORD_W];
                    lim2_next  = SQ_W'(dl_reg) * SQ_W'(dl_reg);
                    addr_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (addr_reg == n_eff) begin
                    drn_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    rd_vld_next = 1'b1;
                    addr_next   = addr_reg + CW'(1);
                end
            end
            ST_DRAIN: begin
                // let the last candidate ripple through every cell
                if (drn_reg == DRW'(DRAIN_LEN - 1)) begin
                    j_next     = '0;
                    found_next = '0;
                    for (int c = 0; c < NUM_VAL; c++) begin
                        sum_next[c] = '0;
                    end
                    state_next = ST_SUM;
                end else begin
                    drn_next = drn_reg + DRW'(1);
                end
            end
            ST_SUM: begin
                if (sel_vld) begin
                    found_next = found_reg + KW'(1);
                    for (int c = 0; c < NUM_VAL; c++) begin
                        sum_next[c] = sum_reg[c]
                                    + SUM_W'($signed(sel_data[c*VAL_W +: VAL_W]));
                    end
                end
                j_next = j_reg + JW'(1);
                if (KW'(j_reg) == (k_eff - KW'(1))) begin
                    state_next = ST_DIVLD;
                end
            end
            ST_DIVLD: begin
                div_ctl.load = 1'b1;
                dcnt_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                div_ctl.step = 1'b1;
                if (dcnt_reg == DVW'(SUM_W - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    dcnt_next = dcnt_reg + DVW'(1);
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = out_word;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            nc_reg       <= NC_W'(4);
            dl_reg       <= DL_W'(65535);
            pc_reg       <= '0;
            addr_reg     <= '0;
            drn_reg      <= '0;
            j_reg        <= '0;
            dcnt_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            nc_reg       <= nc_next;
            dl_reg       <= dl_next;
            pc_reg       <= pc_next;
            addr_reg     <= addr_next;
            drn_reg      <= drn_next;
            j_reg        <= j_next;
            dcnt_reg     <= dcnt_next;
        end
        found_reg   <= found_next;
        m_tdata_reg <= m_tdata_next;
        qx_reg      <= qx_next;
        qy_reg      <= qy_next;
        lim2_reg    <= lim2_next;
        for (int c = 0; c < NUM_VAL; c++) begin
            sum_reg[c] <= sum_next[c];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/knn_cell.sv =====
module knn_cell #(
    parameter int KEY_W  = 41,
    parameter int DATA_W = 48
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clr,
    input  logic              in_vld,
    input  logic [KEY_W-1:0]  in_key,
    input  logic [DATA_W-1:0] in_data,
    output logic              fwd_vld,
    output logic [KEY_W-1:0]  fwd_key,
    output logic [DATA_W-1:0] fwd_data,
    output logic              hold_vld,
    output logic [DATA_W-1:0] hold_data
);

    logic              hold_vld_reg, hold_vld_next;
    logic [KEY_W-1:0]  hold_key_reg, hold_key_next;
    logic [DATA_W-1:0] hold_data_reg, hold_data_next;
    logic              fwd_vld_reg, fwd_vld_next;
    logic [KEY_W-1:0]  fwd_key_reg, fwd_key_next;
    logic [DATA_W-1:0] fwd_data_reg, fwd_data_next;
    logic              take;

    // key is {distance, slot}, so equal distances order by slot
    assign take = in_vld && (!hold_vld_reg || (in_key < hold_key_reg));

    always_comb begin
        hold_vld_next  = hold_vld_reg;
        hold_key_next  = hold_key_reg;
        hold_data_next = hold_data_reg;
        fwd_vld_next   = 1'b0;
        fwd_key_next   = in_key;
        fwd_data_next  = in_data;
        if (take) begin
            hold_vld_next  = 1'b1;
            hold_key_next  = in_key;
            hold_data_next = in_data;
            fwd_vld_next   = hold_vld_reg;
            fwd_key_next   = hold_key_reg;
            fwd_data_next  = hold_data_reg;
        end else if (in_vld) begin
            fwd_vld_next = 1'b1;
        end
        if (clr) begin
            hold_vld_next = 1'b0;
            fwd_vld_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
            fwd_vld_reg  <= 1'b0;
        end else begin
            hold_vld_reg <= hold_vld_next;
            fwd_vld_reg  <= fwd_vld_next;
        end
        hold_key_reg  <= hold_key_next;
        hold_data_reg <= hold_data_next;
        fwd_key_reg   <= fwd_key_next;
        fwd_data_reg  <= fwd_data_next;
    end

    assign fwd_vld   = fwd_vld_reg;
    assign fwd_key   = fwd_key_reg;
    assign fwd_data  = fwd_data_reg;
    assign hold_vld  = hold_vld_reg;
    assign hold_data = hold_data_reg;

endmodule

// ===== rtl/knn_div.sv =====
module knn_div #(
    parameter int SUM_W = 20,
    parameter int K_W   = 4
) (
    input  logic                     aclk,
    input  knn_pkg::div_ctl_t        ctl,
    input  logic signed [SUM_W-1:0]  dividend,
    input  logic [K_W-1:0]           divisor,
    output knn_pkg::val_t            quotient
);

    import knn_pkg::*;

    logic             neg_reg, neg_next;
    logic [SUM_W-1:0] q_reg, q_next;
    logic [K_W-1:0]   rem_reg, rem_next;
    logic [K_W-1:0]   div_reg, div_next;
    logic [K_W:0]     rem_sh;
    logic [K_W:0]     rem_sub;
    logic             ge;
    logic [SUM_W-1:0] q_signed;

    // restoring divide on the magnitude, one quotient bit per step
    assign rem_sh  = {rem_reg, q_reg[SUM_W-1]};
    assign ge      = rem_sh >= {1'b0, div_reg};
    assign rem_sub = rem_sh - {1'b0, div_reg};

    always_comb begin
        neg_next = neg_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        if (ctl.load) begin
            neg_next = dividend[SUM_W-1];
            q_next   = dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
            rem_next = '0;
            div_next = divisor;
        end else if (ctl.step) begin
            q_next   = {q_reg[SUM_W-2:0], ge};
            rem_next = ge ? rem_sub[K_W-1:0] : rem_sh[K_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign q_signed = neg_reg ? (SUM_W'(0) - q_reg) : q_reg;
    assign quotient = val_t'(q_signed[VAL_W-1:0]);

endmodule
